// ----- design/spv_pkg.sv -----
// ----------------------------------------------------------------------------
// spv_pkg
// shared constants for the sampler voice: default sizes, config register
// indexes, envelope limits and fixed-point scaling
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int DEF_MAX_FRAMES  = 65536;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd6;

    localparam logic [1:0] CHAN_STEREO = 2'd2;

    localparam logic [16:0] ENV_ONE       = 17'h10000;
    localparam logic [16:0] ENV_THRESHOLD = 17'd6;

    localparam int GUARD_BITS = 8;
    localparam int ACC_W      = 60;
    localparam int ROUND_SH   = 37;

endpackage

// ----- design/sample_playback_voice.sv -----
// ----------------------------------------------------------------------------
// sample_playback_voice
// sampler voice with stereo sample store, linear attack/release envelope and
// catmull-rom cubic read-out, all products formed by one bit-serial multiplier
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
// input    | i_valid / o_ready          | i_cmd, i_note_on, i_load_*
// output   | o_valid / i_ready          | o_left_out, o_right_out, o_voice_active
//
// load transaction: serial address reduction, then store write
// a silent or ended tick goes straight to the output push; an audible tick runs
// the serial multiplier through ten products of MB bits (MB = 17 here)
// one transaction is in work at a time; the output register frees the core
// reset is synchronous; the sample store keeps no reset
// ----------------------------------------------------------------------------
module sample_playback_voice #(
    parameter int MAX_FRAMES  = spv_pkg::DEF_MAX_FRAMES,
    parameter int SAMPLE_BITS = spv_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = spv_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic                          i_note_on,
    input  logic [15:0]                   i_load_address,
    input  logic signed [15:0]            i_load_left,
    input  logic signed [15:0]            i_load_right,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [15:0]            o_left_out,
    output logic signed [15:0]            o_right_out,
    output logic                          o_voice_active
);

    import spv_pkg::*;

    localparam int AIW       = $clog2(MAX_FRAMES);
    localparam int LENW      = $clog2(MAX_FRAMES + 1);
    localparam int CW        = (LENW > 17) ? LENW : 17;
    localparam int IPW       = ((AIW > 8) ? AIW : 8) + 1;
    localparam int POSW      = IPW + FRAC_BITS;
    localparam int MB        = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int PW        = ACC_W + 1 + MB;
    localparam int STEP_UP   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int SHW       = 24 + STEP_UP;
    localparam int QW        = ACC_W - ROUND_SH;
    localparam int SAT_HI_I  = (SAMPLE_BITS > 16) ? 32767 : (1 << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [QW-1:0]    SAT_HI   = QW'(SAT_HI_I);
    localparam logic signed [QW-1:0]    SAT_LO   = -SAT_HI - QW'(1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (ROUND_SH - 1));

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LMOD   = 3'd1;
    localparam logic [2:0] S_LWR    = 3'd2;
    localparam logic [2:0] S_TAP    = 3'd3;
    localparam logic [2:0] S_MSTART = 3'd4;
    localparam logic [2:0] S_MWAIT  = 3'd5;
    localparam logic [2:0] S_PUSH   = 3'd6;

    // config
    logic [23:0] r_phase_step;
    logic [16:0] r_attack_step;
    logic [16:0] r_release_step;
    logic [15:0] r_wet_gain;
    logic        r_play_mode;
    logic [16:0] r_sample_length;
    logic [1:0]  r_channel_count;

    // playback state
    logic [POSW-1:0] r_pos;
    logic [16:0]     r_env;
    logic            r_play;
    logic            r_prev;

    // sequencer
    logic [2:0]  r_state;
    logic [4:0]  r_cnt;
    logic [2:0]  r_k;
    logic        r_ch;

    logic [15:0]    r_laddr;
    logic [AIW-1:0] r_mod;
    logic [31:0]    r_ldata;

    logic [31:0] mem [0:MAX_FRAMES-1];
    logic [31:0] r_rd_data;

    logic signed [15:0] r_tl [0:3];
    logic signed [15:0] r_tr [0:3];

    logic signed [ACC_W-1:0] r_ma;
    logic [MB-1:0]           r_mb;
    logic                    r_mstart;

    logic signed [15:0] r_res_l;
    logic signed [15:0] r_res_r;
    logic               r_res_act;

    logic               r_ovalid;
    logic signed [15:0] r_oleft;
    logic signed [15:0] r_oright;
    logic               r_oact;

    // tick decision
    logic [LENW-1:0] len_c;
    logic            rise;
    logic [POSW-1:0] pos0;
    logic            play0;
    logic            active_in;
    logic [17:0]     env_sum;
    logic [16:0]     env_att;
    logic [16:0]     env_rel;
    logic [16:0]     env1;
    logic [16:0]     env1_rel;
    logic [16:0]     env2;
    logic            alive1;
    logic [IPW-1:0]  ip0;
    logic            at_end;

    // datapath
    logic [IPW-1:0]     ipc;
    logic [IPW-1:0]     addr_w;
    logic [AIW:0]       mod_tmp;
    logic [AIW-1:0]     n_mod;
    logic signed [15:0] y0, y1, y2, y3;
    logic signed [20:0] c3, c2, c1;
    logic               mbusy;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_fl;
    logic signed [31:0]      fl32;
    logic signed [31:0]      v32;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] qf;
    logic signed [QW-1:0]    q;
    logic signed [15:0]      q_sat;
    logic [POSW-1:0]         step_pos;
    logic                    stereo;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);

    assign len_c = (CW'(r_sample_length) > CW'(MAX_FRAMES)) ? LENW'(MAX_FRAMES)
                                                            : LENW'(r_sample_length);
    assign rise      = i_note_on & ~r_prev;
    assign pos0      = rise ? '0 : r_pos;
    assign play0     = (rise | r_play) & (r_play_mode | i_note_on);
    assign active_in = play0 | (r_env > ENV_THRESHOLD);
    assign env_sum   = {1'b0, r_env} + {1'b0, r_attack_step};
    assign env_att   = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[16:0];
    assign env_rel   = (r_env > r_release_step) ? r_env - r_release_step : '0;
    assign env1      = play0 ? env_att : env_rel;
    assign env1_rel  = (env1 > r_release_step) ? env1 - r_release_step : '0;
    assign env2      = (r_play_mode) ? env1_rel : env1;
    assign alive1    = play0 | (env1 > ENV_THRESHOLD);
    assign ip0       = pos0[POSW-1:FRAC_BITS];
    assign at_end    = (len_c < LENW'(4)) || (ip0 >= IPW'(len_c) - IPW'(3));

    assign ipc    = r_pos[POSW-1:FRAC_BITS];
    assign addr_w = (r_cnt == 5'd0) ? ((ipc == '0) ? '0 : ipc - IPW'(1))
                                    : ipc + IPW'(r_cnt) - IPW'(1);

    assign mod_tmp = {r_mod, r_laddr[15]};
    assign n_mod   = (mod_tmp >= (AIW+1)'(MAX_FRAMES)) ? AIW'(mod_tmp - (AIW+1)'(MAX_FRAMES))
                                                       : AIW'(mod_tmp);

    assign stereo = r_ch && (r_channel_count == CHAN_STEREO);
    assign y0 = stereo ? r_tr[0] : r_tl[0];
    assign y1 = stereo ? r_tr[1] : r_tl[1];
    assign y2 = stereo ? r_tr[2] : r_tl[2];
    assign y3 = stereo ? r_tr[3] : r_tl[3];
    assign c3 = -21'(y0) + 21'(y1) * 21'sd3 - 21'(y2) * 21'sd3 + 21'(y3);
    assign c2 = 21'(y0) * 21'sd2 - 21'(y1) * 21'sd5 + 21'(y2) * 21'sd4 - 21'(y3);
    assign c1 = 21'(y2) - 21'(y0);

    assign prod_fl = prod >>> FRAC_BITS;
    assign fl32    = prod_fl[31:0];
    assign v32     = (32'(y1) <<< (GUARD_BITS + 1)) + fl32;
    assign rnd     = prod[ACC_W-1:0] + RND_HALF;
    assign qf      = rnd >>> ROUND_SH;
    assign q       = qf[QW-1:0];
    assign q_sat   = (q > SAT_HI) ? 16'(SAT_HI) : ((q < SAT_LO) ? 16'(SAT_LO) : q[15:0]);

    assign step_pos = POSW'((SHW'(r_phase_step) << STEP_UP) >> STEP_DOWN);

    spv_sermul #(
        .AW (ACC_W),
        .BW (MB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_busy  (mbusy),
        .o_prod  (prod)
    );

    // sample store
    always_ff @(posedge i_clk) begin
        if (r_state == S_LWR) begin
            mem[r_mod] <= r_ldata;
        end
        if (r_state == S_TAP) begin
            r_rd_data <= mem[addr_w[AIW-1:0]];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= 24'd65536;
            r_attack_step   <= 17'd65536;
            r_release_step  <= 17'd65536;
            r_wet_gain      <= 16'd4096;
            r_play_mode     <= 1'b0;
            r_sample_length <= '0;
            r_channel_count <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data;
                CFG_ATTACK_STEP:   r_attack_step   <= i_cfg_data[16:0];
                CFG_RELEASE_STEP:  r_release_step  <= i_cfg_data[16:0];
                CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data[15:0];
                CFG_PLAY_MODE:     r_play_mode     <= i_cfg_data[0];
                CFG_SAMPLE_LENGTH: r_sample_length <= i_cfg_data[16:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_k      <= '0;
            r_ch     <= 1'b0;
            r_pos    <= '0;
            r_env    <= '0;
            r_play   <= 1'b0;
            r_prev   <= 1'b0;
            r_mstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd) begin
                            r_pos   <= '0;
                            r_env   <= '0;
                            r_play  <= 1'b0;
                            r_prev  <= 1'b0;
                            r_cnt   <= '0;
                            r_laddr <= i_load_address;
                            r_mod   <= '0;
                            r_state <= S_LMOD;
                        end else begin
                            r_res_l   <= '0;
                            r_res_r   <= '0;
                            r_res_act <= 1'b0;
                            r_state   <= S_PUSH;
                            if (len_c != '0) begin
                                r_prev <= i_note_on;
                                r_pos  <= pos0;
                                r_play <= play0;
                                if (active_in) begin
                                    r_env <= env1;
                                    if (alive1) begin
                                        if (at_end) begin
                                            r_play    <= 1'b0;
                                            r_env     <= env2;
                                            r_res_act <= (env2 > ENV_THRESHOLD);
                                        end else begin
                                            r_res_act <= 1'b1;
                                            r_cnt     <= '0;
                                            r_state   <= S_TAP;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                S_LMOD: begin
                    r_mod   <= n_mod;
                    r_laddr <= {r_laddr[14:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_LWR;
                    end
                end
                S_LWR: begin
                    r_state <= S_IDLE;
                end
                S_TAP: begin
                    if (r_cnt != '0) begin
                        r_tl[r_cnt[1:0] - 2'd1] <= r_rd_data[15:0];
                        r_tr[r_cnt[1:0] - 2'd1] <= r_rd_data[31:16];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd4) begin
                        r_k     <= '0;
                        r_ch    <= 1'b0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    if (r_k == 3'd0) begin
                        r_ma <= ACC_W'(c3) <<< GUARD_BITS;
                        r_mb <= MB'(r_pos[FRAC_BITS-1:0]);
                    end
                    r_mstart <= 1'b1;
                    r_state  <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (!mbusy && !r_mstart) begin
                        r_state <= S_MSTART;
                        r_k     <= r_k + 1'b1;
                        case (r_k)
                            3'd0: r_ma <= ACC_W'(fl32 + (32'(c2) <<< GUARD_BITS));
                            3'd1: r_ma <= ACC_W'(fl32 + (32'(c1) <<< GUARD_BITS));
                            3'd2: begin
                                r_ma <= ACC_W'(v32);
                                r_mb <= MB'(r_env);
                            end
                            3'd3: begin
                                r_ma <= prod[ACC_W-1:0];
                                r_mb <= MB'(r_wet_gain);
                            end
                            default: begin
                                r_k <= '0;
                                if (r_ch) begin
                                    r_res_r <= q_sat;
                                    r_pos   <= r_pos + step_pos;
                                    r_state <= S_PUSH;
                                end else begin
                                    r_res_l <= q_sat;
                                    r_ch    <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_oleft  <= r_res_l;
                        r_oright <= r_res_r;
                        r_oact   <= r_res_act;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // load payload capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && i_cmd) begin
            r_ldata <= {i_load_right, i_load_left};
        end
    end

    assign o_valid        = r_ovalid;
    assign o_left_out     = r_oleft;
    assign o_right_out    = r_oright;
    assign o_voice_active = r_oact;

endmodule

// ----- design/spv_sermul.sv -----
// ----------------------------------------------------------------------------
// spv_sermul
// bit-serial shift-add multiplier, signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module spv_sermul #(
    parameter int AW = 60,
    parameter int BW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic        [BW-1:0] i_b,
    output logic                 o_busy,
    output logic signed [AW+BW:0] o_prod
);

    localparam int CNTW = $clog2(BW + 1);

    logic signed [AW-1:0] r_a;
    logic signed [AW:0]   r_hi;
    logic        [BW-1:0] r_lo;
    logic      [CNTW-1:0] r_cnt;
    logic                 r_busy;
    logic signed [AW:0]   sum;

    assign sum = r_hi + (r_lo[0] ? {r_a[AW-1], r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(BW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {sum[AW], sum[AW:1]};
            r_lo <= {sum[0], r_lo[BW-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi, r_lo};

endmodule

// ----- bench/tb_sample_playback_voice.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_playback_voice
// self-checking bench for the sampler voice: a queue-fed driver, a monitor
// that compares every output frame against an in-bench voice predictor, and
// phases of register settings with varying source and sink throttling
// ----------------------------------------------------------------------------
module tb_sample_playback_voice;
    import spv_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic        cmd;
        logic        note;
        logic [15:0] addr;
        logic [15:0] left;
        logic [15:0] right;
    } voice_item_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        active;
    } voice_frame_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_cmd = 1'b0;
    logic i_note_on = 1'b0;
    logic [15:0] i_load_address = '0;
    logic signed [15:0] i_load_left = '0;
    logic signed [15:0] i_load_right = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;
    logic o_voice_active;

    sample_playback_voice dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0] store_mem [0:65535];
    bit loaded_mem [0:65535];
    longint play_pos;
    int env_lvl;
    bit playing, prev_note;
    int r_phase, r_attack, r_release, r_gain, r_mode, r_length, r_chan;
    int miss_idx;

    voice_item_t pending_items [$];
    voice_frame_t expected_frames [$];
    int idle_mode;
    int mismatches;
    int quiet_cycles;

    function automatic longint tap_val(int idx, bit right);
        logic [31:0] w;
        if (!loaded_mem[idx]) miss_idx = idx;
        w = store_mem[idx];
        return right ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
    endfunction

    function automatic longint cubic_value(int len, longint pos, bit right);
        longint ip, f, y0, y1, y2, y3, c1, c2, c3, t;
        int i0, i1, i2, i3;
        ip = pos >>> 16;
        i1 = int'((ip > len - 1) ? longint'(len - 1) : ip);
        i0 = (i1 > 0) ? i1 - 1 : 0;
        i2 = (i1 + 1 > len - 1) ? len - 1 : i1 + 1;
        i3 = (i1 + 2 > len - 1) ? len - 1 : i1 + 2;
        f = pos & 64'hFFFF;
        y0 = tap_val(i0, right);
        y1 = tap_val(i1, right);
        y2 = tap_val(i2, right);
        y3 = tap_val(i3, right);
        c3 = -y0 + 3 * y1 - 3 * y2 + y3;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c1 = -y0 + y2;
        t = c3 * 256;
        t = ((t * f) >>> 16) + c2 * 256;
        t = ((t * f) >>> 16) + c1 * 256;
        t = (t * f) >>> 16;
        return y1 * 512 + t;
    endfunction

    function automatic logic [15:0] scaled_out(longint v);
        longint p, r;
        p = v * longint'(env_lvl) * longint'(r_gain);
        r = (p + (64'sd1 <<< 36)) >>> 37;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void release_env();
        env_lvl = (env_lvl > r_release) ? env_lvl - r_release : 0;
    endfunction

    function automatic void voice_step(voice_item_t it, output bit produced,
                                       output voice_frame_t fr);
        int len;
        bit oneshot;
        oneshot = r_mode != 0;
        fr = '0;
        produced = 1'b0;
        if (it.cmd == CMD_LOAD) begin
            store_mem[it.addr] = {it.right, it.left};
            loaded_mem[it.addr] = 1'b1;
            play_pos = 0;
            env_lvl = 0;
            playing = 1'b0;
            prev_note = 1'b0;
            return;
        end
        produced = 1'b1;
        len = (r_length < 65536) ? r_length : 65536;
        if (len == 0) return;
        if (it.note && !prev_note) begin
            play_pos = 0;
            playing = 1'b1;
        end
        prev_note = it.note;
        if (!oneshot && !it.note) playing = 1'b0;
        if (playing || env_lvl > int'(ENV_THRESHOLD)) begin
            if (playing && (oneshot || it.note)) begin
                env_lvl += r_attack;
                if (env_lvl > int'(ENV_ONE)) env_lvl = int'(ENV_ONE);
            end else begin
                release_env();
            end
            if (playing || env_lvl > int'(ENV_THRESHOLD)) begin
                if (len < 4 || play_pos >= (longint'(len - 3) << 16)) begin
                    playing = 1'b0;
                    if (oneshot) release_env();
                end else begin
                    fr.left = scaled_out(cubic_value(len, play_pos, 1'b0));
                    fr.right = scaled_out(cubic_value(len, play_pos, r_chan == CHAN_STEREO));
                    play_pos += r_phase;
                end
            end
        end
        fr.active = playing || env_lvl > int'(ENV_THRESHOLD);
    endfunction

    // queue one transaction; a tick that would touch an unloaded frame
    // becomes a load of that frame
    task automatic queue_item(voice_item_t it);
        longint sv_pos;
        int sv_env;
        bit sv_play, sv_prev, produced;
        voice_frame_t fr;
        if (it.cmd == CMD_TICK) begin
            sv_pos = play_pos;
            sv_env = env_lvl;
            sv_play = playing;
            sv_prev = prev_note;
            miss_idx = -1;
            voice_step(it, produced, fr);
            play_pos = sv_pos;
            env_lvl = sv_env;
            playing = sv_play;
            prev_note = sv_prev;
            if (miss_idx >= 0) begin
                it.cmd = CMD_LOAD;
                it.addr = miss_idx[15:0];
                it.left = 16'($urandom);
                it.right = 16'($urandom);
            end
        end
        voice_step(it, produced, fr);
        pending_items.push_back(it);
        if (produced) expected_frames.push_back(fr);
    endtask

    function automatic voice_item_t make_load(int addr, int left, int right);
        voice_item_t it;
        it.cmd = CMD_LOAD;
        it.note = 1'($urandom);
        it.addr = addr[15:0];
        it.left = left[15:0];
        it.right = right[15:0];
        return it;
    endfunction

    function automatic voice_item_t make_tick(bit note);
        voice_item_t it;
        it.cmd = CMD_TICK;
        it.note = note;
        it.addr = 16'($urandom);
        it.left = 16'($urandom);
        it.right = 16'($urandom);
        return it;
    endfunction

    task automatic wait_idle();
        wait (pending_items.size() == 0 && expected_frames.size() == 0 && !i_valid);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:    r_phase = int'(data & 24'hFFFFFF);
            CFG_ATTACK_STEP:   r_attack = int'(data & 24'h1FFFF);
            CFG_RELEASE_STEP:  r_release = int'(data & 24'h1FFFF);
            CFG_WET_GAIN:      r_gain = int'(data & 24'hFFFF);
            CFG_PLAY_MODE:     r_mode = int'(data & 24'h1);
            CFG_SAMPLE_LENGTH: r_length = int'(data & 24'h1FFFF);
            CFG_CHANNEL_COUNT: r_chan = int'(data & 24'h3);
            default: ;
        endcase
    endtask

    task automatic random_config(int p);
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 3))
            0: d = '0;
            1: d = 24'hFFFFFF;
            default: d = 24'($urandom_range(1, 24'h30000));
        endcase
        write_reg(CFG_PHASE_STEP, d);
        write_reg(CFG_ATTACK_STEP, 24'(($urandom_range(0, 3) == 0) ? 24'h10000 :
                  (($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 24'h4000))));
        write_reg(CFG_RELEASE_STEP, 24'(($urandom_range(0, 3) == 0) ? 24'h10000 :
                  (($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 24'h4000))));
        write_reg(CFG_WET_GAIN, 24'(($urandom_range(0, 2) == 0) ? 24'hFFFF : $urandom));
        write_reg(CFG_PLAY_MODE, 24'($urandom));
        case (p % 6)
            0: d = 24'($urandom_range(0, 3));
            1: d = 24'h10000;
            2: d = ($urandom_range(0, 1) == 1) ? 24'hFFFF : {7'h7F, 17'h1FFFF};
            default: d = 24'($urandom_range(4, 40));
        endcase
        write_reg(CFG_SAMPLE_LENGTH, d);
        write_reg(CFG_CHANNEL_COUNT, 24'($urandom));
    endtask

    task automatic random_items(int count);
        bit note;
        int len;
        note = 1'b0;
        len = (r_length < 65536) ? r_length : 65536;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) note = ~note;
            if ($urandom_range(0, 24) == 0)
                queue_item(make_load(($urandom_range(0, 3) == 0) ? $urandom :
                                     $urandom_range(0, len + 3), $urandom, $urandom));
            else
                queue_item(make_tick(($urandom_range(0, 19) == 0) ? ~note : note));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        voice_item_t it;
        bit hold, go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            hold = i_valid && !o_ready;
            go = (idle_mode == 1) ? ($urandom_range(0, 99) >= 79) :
                 (idle_mode == 3) ? ($urandom_range(0, 99) >= 27) : 1'b1;
            if (!hold) begin
                if (go && pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= it.cmd;
                    i_note_on <= it.note;
                    i_load_address <= it.addr;
                    i_load_left <= it.left;
                    i_load_right <= it.right;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, sink throttling and watchdog
    always @(posedge i_clk) begin
        voice_frame_t ex;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            i_ready <= (idle_mode == 2) ? ($urandom_range(0, 99) >= 79) :
                       (idle_mode == 3) ? ($urandom_range(0, 99) >= 27) : 1'b1;
            if (o_valid && i_ready) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output transaction");
                end else begin
                    ex = expected_frames.pop_front();
                    if (ex.left !== o_left_out || ex.right !== o_right_out ||
                        ex.active !== o_voice_active) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp l=%0d r=%0d a=%0b got l=%0d r=%0d a=%0b",
                                     $signed(ex.left), $signed(ex.right), ex.active,
                                     o_left_out, o_right_out, o_voice_active);
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sample_playback_voice verification failed");
                $finish;
            end
        end
    end

    initial begin
        int len;
        idle_mode = 0;
        mismatches = 0;
        play_pos = 0;
        env_lvl = 0;
        playing = 0;
        prev_note = 0;
        r_phase = 65536;
        r_attack = 65536;
        r_release = 65536;
        r_gain = 4096;
        r_mode = 0;
        r_length = 0;
        r_chan = 1;
        foreach (loaded_mem[k]) loaded_mem[k] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: ticks give silence, then a load to the top frame
        queue_item(make_tick(1'b1));
        queue_item(make_tick(1'b0));
        queue_item(make_load(16'hFFFF, 32767, -32768));
        wait_idle();

        // short stereo sample with full-scale taps, end and note-off handling
        write_reg(CFG_PHASE_STEP, 24'h8000);
        write_reg(CFG_WET_GAIN, 24'hFFFF);
        write_reg(CFG_CHANNEL_COUNT, 24'(CHAN_STEREO));
        write_reg(CFG_SAMPLE_LENGTH, 24'd6);
        write_reg(CFG_UNUSED_IDX, 24'h123456);
        queue_item(make_load(0, 32767, -32768));
        queue_item(make_load(1, -32768, 32767));
        queue_item(make_load(2, 32767, 32767));
        queue_item(make_load(3, -32768, -32768));
        queue_item(make_load(4, 0, -1));
        queue_item(make_load(5, -1, 0));
        for (int n = 0; n < 8; n++) queue_item(make_tick(1'b1));
        for (int n = 0; n < 3; n++) queue_item(make_tick(1'b0));
        wait_idle();
        write_reg(CFG_PLAY_MODE, 24'd1);
        write_reg(CFG_RELEASE_STEP, 24'h1000);
        write_reg(CFG_SAMPLE_LENGTH, 24'd3);
        queue_item(make_tick(1'b1));
        queue_item(make_tick(1'b1));
        wait_idle();

        for (int p = 0; p < 11; p++) begin
            idle_mode = p % 4;
            random_config(p);
            len = (r_length < 65536) ? r_length : 65536;
            for (int a = 0; a < len && a < 40; a++)
                queue_item(make_load(a, $urandom, $urandom));
            random_items(12);
            if (p == 5) wait (pending_items.size() == 0 && expected_frames.size() == 0);
            random_items(12);
            wait_idle();
        end

        if (mismatches == 0 && expected_frames.size() == 0)
            $display("sample_playback_voice verification clean");
        else
            $display("sample_playback_voice verification failed");
        $finish;
    end
endmodule
